### sv/cdc_pkg.sv
package cdc_pkg;

  // drive select field is three bits, so at most eight units
  localparam int MAX_UNITS = 8;
  localparam int DRIVE_UNITS_DEF = 8;

  // configuration port
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;
  localparam int LIMIT_W = 19;
  localparam logic CFG_DRIVES = 1'b0;
  localparam logic CFG_LIMIT  = 1'b1;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 19'h40000;

  // request actions
  localparam logic [1:0] ACT_READ  = 2'd0;
  localparam logic [1:0] ACT_WRITE = 2'd1;
  localparam logic [1:0] ACT_STEP  = 2'd2;

  // register word offsets
  localparam logic [2:0] REG_DS = 3'd0;
  localparam logic [2:0] REG_ER = 3'd1;
  localparam logic [2:0] REG_CS = 3'd2;
  localparam logic [2:0] REG_WC = 3'd3;
  localparam logic [2:0] REG_BA = 3'd4;
  localparam logic [2:0] REG_DA = 3'd5;
  localparam logic [2:0] REG_DB = 3'd7;

  // control functions
  localparam logic [2:0] FN_RESET = 3'd0;
  localparam logic [2:0] FN_WRITE = 3'd1;
  localparam logic [2:0] FN_READ  = 3'd2;

  // control and status bits
  localparam logic [15:0] CS_GO    = 16'h0001;
  localparam logic [15:0] CS_RDY   = 16'h0080;
  localparam logic [15:0] CS_B13   = 16'h2000;
  localparam logic [15:0] CS_HARD  = 16'h4000;
  localparam logic [15:0] CS_ERR   = 16'h8000;
  localparam logic [15:0] CS_WMASK = 16'o6577;
  localparam logic [15:0] HARD_MASK = 16'o177740;
  localparam int CS_IDE_BIT = 6;
  localparam int CS_SSE_BIT = 8;
  localparam int CS_IBA_BIT = 10;
  localparam int CS_HARD_BIT = 14;
  localparam logic [15:0] DS_ARDY  = 16'h0040;
  localparam logic [15:0] DS_RESET = 16'o4300;

  // error bits
  localparam logic [15:0] ER_NXS = 16'h0020;
  localparam logic [15:0] ER_NXC = 16'h0040;
  localparam logic [15:0] ER_NXD = 16'h0080;
  localparam logic [15:0] ER_NXM = 16'h0400;
  localparam logic [15:0] ER_OVR = 16'h4000;

  // disk geometry
  localparam logic [7:0] MAX_CYL   = 8'o312;
  localparam logic [3:0] MAX_SEC   = 4'o13;
  localparam logic [8:0] CYLINDERS = 9'd203;
  localparam logic [4:0] SECTORS   = 5'd12;
  localparam logic [12:0] SURF_SECTORS = 13'd12;

  typedef struct packed {
    logic [1:0]  action;
    logic [2:0]  reg_index;
    logic        byte_access;
    logic        odd_byte;
    logic [15:0] write_data;
  } item_t;

  typedef struct packed {
    logic [15:0] read_data;
    logic        dma_valid;
    logic [17:0] dma_addr;
    logic        dma_to_memory;
    logic [2:0]  drive_unit;
    logic [12:0] disk_sector;
    logic [7:0]  word_in_sector;
    logic        sector_end;
    logic        interrupt_request;
    logic        busy_res;
  } result_t;

endpackage

### sv/cdc_cfg.sv
module cdc_cfg
  import cdc_pkg::*;
#(
  parameter int DRIVE_UNITS = DRIVE_UNITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [CFG_AW-1:0]      paddr,
  input  logic [CFG_DW-1:0]      pwdata,
  output logic [CFG_DW-1:0]      prdata,
  output logic                   pready,
  output logic [DRIVE_UNITS-1:0] drives_attached,
  output logic [LIMIT_W-1:0]     memory_limit
);

  logic [DRIVE_UNITS-1:0] drives_r;
  logic [LIMIT_W-1:0]     limit_r;
  logic                   wr_en;
  logic                   idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[2];

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      drives_r <= '0;
      limit_r  <= LIMIT_RESET;
    end else if (wr_en) begin
      case (idx)
        CFG_DRIVES: drives_r <= pwdata[DRIVE_UNITS-1:0];
        CFG_LIMIT:  limit_r  <= pwdata[LIMIT_W-1:0];
        default:    ;
      endcase
    end
  end

  // readback
  always_comb begin
    case (idx)
      CFG_DRIVES: prdata = CFG_DW'(drives_r);
      CFG_LIMIT:  prdata = CFG_DW'(limit_r);
      default:    prdata = '0;
    endcase
  end

  assign drives_attached = drives_r;
  assign memory_limit    = limit_r;

endmodule

### sv/cdc_core.sv
module cdc_core
  import cdc_pkg::*;
#(
  parameter int DRIVE_UNITS = DRIVE_UNITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   proc,
  input  item_t                  item,
  input  logic [DRIVE_UNITS-1:0] drives_attached,
  input  logic [LIMIT_W-1:0]     memory_limit,
  output result_t                res
);

  logic [15:0] ds_r, ds_nxt, er_r, er_nxt, cs_r, cs_nxt, wc_r, wc_nxt;
  logic [15:0] ba_r, ba_nxt, da_r, da_nxt, db_r, db_nxt;
  logic        act_r, act_nxt, rds_r, rds_nxt;
  logic [7:0]  pos_r, pos_nxt;
  logic [MAX_UNITS-1:0] att_ext;
  logic        irq;

  function automatic logic [15:0] set_val(logic [15:0] r, logic [15:0] v,
                                          logic b, logic odd);
    logic [15:0] o;
    if (!b)       o = v;
    else if (odd) o = {v[7:0], r[7:0]};
    else          o = {r[15:8], v[7:0]};
    return o;
  endfunction

  function automatic logic [15:0] get_val(logic [15:0] r, logic b, logic odd);
    logic [15:0] o;
    if (!b)       o = r;
    else if (odd) o = {8'h00, r[15:8]};
    else          o = {8'h00, r[7:0]};
    return o;
  endfunction

  // attach bits widened to the full drive select range
  always_comb begin
    att_ext = '0;
    att_ext[DRIVE_UNITS-1:0] = drives_attached;
  end

  // one request against the register file and sequencer
  always_comb begin
    logic [15:0] rv, wv, csw, err, wc_n, ba_n;
    logic [17:0] ba18;
    logic [2:0]  drv, fn;
    logic [7:0]  cyl;
    logic        surf, surf_n, over, fin;
    logic [3:0]  sec;
    logic [4:0]  sec_n;
    logic [8:0]  cyl_n;

    ds_nxt  = ds_r;
    er_nxt  = er_r;
    cs_nxt  = cs_r;
    wc_nxt  = wc_r;
    ba_nxt  = ba_r;
    da_nxt  = da_r;
    db_nxt  = db_r;
    act_nxt = act_r;
    rds_nxt = rds_r;
    pos_nxt = pos_r;
    res     = '0;
    irq     = 1'b0;
    err     = '0;
    fin     = 1'b0;
    over    = 1'b0;
    rv      = '0;
    wv      = set_val(16'h0000, item.write_data, 1'b0, 1'b0);
    csw     = cs_r;
    fn      = FN_RESET;
    wc_n    = wc_r + 16'd1;
    ba_n    = ba_r + 16'd2;
    ba18    = {cs_r[5:4], ba_r};
    drv     = da_r[15:13];
    cyl     = da_r[12:5];
    surf    = da_r[4];
    sec     = da_r[3:0];
    sec_n   = {1'b0, sec} + 5'd1;
    surf_n  = surf;
    cyl_n   = {1'b0, cyl};

    if (proc) begin
      case (item.action)
        ACT_READ: begin
          case (item.reg_index)
            REG_DS:  rv = ds_r;
            REG_ER:  rv = er_r;
            REG_CS:  rv = cs_r;
            REG_WC:  rv = wc_r;
            REG_BA:  rv = ba_r;
            REG_DA:  rv = da_r;
            REG_DB:  rv = db_r;
            default: rv = '0;
          endcase
          res.read_data = get_val(rv, item.byte_access, item.odd_byte);
        end
        ACT_WRITE: begin
          case (item.reg_index)
            REG_CS: begin
              wv  = set_val(cs_r, item.write_data, item.byte_access, item.odd_byte);
              csw = (cs_r & ~CS_WMASK) | (wv & CS_WMASK);
              cs_nxt = csw;
              if ((csw & CS_GO) != 16'h0000) begin
                cs_nxt = csw & ~(CS_B13 | CS_GO);
                fn = cs_nxt[3:1];
                case (fn)
                  FN_RESET: begin
                    ds_nxt  = DS_RESET;
                    er_nxt  = '0;
                    cs_nxt  = CS_RDY;
                    wc_nxt  = '0;
                    ba_nxt  = '0;
                    da_nxt  = '0;
                    db_nxt  = '0;
                    act_nxt = 1'b0;
                    rds_nxt = 1'b0;
                    pos_nxt = '0;
                  end
                  FN_WRITE, FN_READ: begin
                    ds_nxt  = ds_r & ~DS_ARDY;
                    cs_nxt  = cs_nxt & ~CS_RDY;
                    act_nxt = 1'b0;
                    if (!att_ext[drv]) err = ER_NXD;
                    else if (cyl > MAX_CYL) err = ER_NXC;
                    else if (sec > MAX_SEC) err = ER_NXS;
                    else if (wc_r == 16'h0000) fin = 1'b1;
                    else begin
                      act_nxt = 1'b1;
                      rds_nxt = (fn == FN_READ);
                      pos_nxt = '0;
                    end
                  end
                  default: irq = 1'b1;
                endcase
              end
            end
            REG_WC: wc_nxt = set_val(wc_r, item.write_data, item.byte_access, item.odd_byte);
            REG_BA: ba_nxt = set_val(ba_r, item.write_data, item.byte_access, item.odd_byte);
            REG_DA: da_nxt = set_val(da_r, item.write_data, item.byte_access, item.odd_byte);
            REG_DB: db_nxt = set_val(db_r, item.write_data, item.byte_access, item.odd_byte);
            default: ;
          endcase
        end
        ACT_STEP: begin
          if (act_r) begin
            if ({1'b0, ba18} >= memory_limit) begin
              err = ER_NXM;
            end else begin
              res.dma_valid      = 1'b1;
              res.dma_addr       = ba18;
              res.dma_to_memory  = rds_r;
              res.drive_unit     = drv;
              res.disk_sector    = 13'({cyl, 4'b0000}) + 13'({cyl, 3'b000})
                                   + (surf ? SURF_SECTORS : 13'd0) + 13'(sec);
              res.word_in_sector = pos_r;
              wc_nxt  = wc_n;
              // bus address advance with carry into the extension bits
              if (!cs_r[CS_IBA_BIT]) begin
                ba_nxt = ba_n;
                if (ba_n == 16'h0000) cs_nxt[5:4] = cs_r[5:4] + 2'd1;
              end
              pos_nxt = pos_r + 8'd1;
              // sector close: advance sector, surface and cylinder
              if (pos_r == 8'hFF || wc_n == 16'h0000) begin
                res.sector_end = 1'b1;
                pos_nxt = '0;
                if (sec_n >= SECTORS) begin
                  sec_n = '0;
                  if (surf) begin
                    surf_n = 1'b0;
                    cyl_n  = cyl_n + 9'd1;
                    over   = (cyl_n >= CYLINDERS);
                  end else begin
                    surf_n = 1'b1;
                  end
                end
                if (over) begin
                  err = ER_OVR;
                end else begin
                  da_nxt = {drv, cyl_n[7:0], surf_n, sec_n[3:0]};
                  if (wc_n == 16'h0000) fin = 1'b1;
                end
              end
            end
          end
        end
        default: ;
      endcase

      // error or completion: raise ready and maybe interrupt
      if (err != 16'h0000) begin
        er_nxt = er_nxt | err;
        cs_nxt = cs_nxt | CS_ERR;
        if ((er_nxt & HARD_MASK) != 16'h0000) cs_nxt = cs_nxt | CS_HARD;
        ds_nxt  = ds_nxt | DS_ARDY;
        cs_nxt  = cs_nxt | CS_RDY;
        act_nxt = 1'b0;
        irq = cs_nxt[CS_IDE_BIT] && (cs_nxt[CS_HARD_BIT] || cs_nxt[CS_SSE_BIT]);
      end else if (fin) begin
        ds_nxt  = ds_nxt | DS_ARDY;
        cs_nxt  = cs_nxt | CS_RDY;
        act_nxt = 1'b0;
        irq = cs_nxt[CS_IDE_BIT];
      end
      res.interrupt_request = irq;
      res.busy_res          = act_nxt;
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ds_r  <= DS_RESET;
      er_r  <= '0;
      cs_r  <= CS_RDY;
      wc_r  <= '0;
      ba_r  <= '0;
      da_r  <= '0;
      db_r  <= '0;
      act_r <= 1'b0;
      rds_r <= 1'b0;
      pos_r <= '0;
    end else begin
      ds_r  <= ds_nxt;
      er_r  <= er_nxt;
      cs_r  <= cs_nxt;
      wc_r  <= wc_nxt;
      ba_r  <= ba_nxt;
      da_r  <= da_nxt;
      db_r  <= db_nxt;
      act_r <= act_nxt;
      rds_r <= rds_nxt;
      pos_r <= pos_nxt;
    end
  end

  // a running transfer keeps ready low in both registers
  a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
    act_r |-> ((cs_r & CS_RDY) == 16'h0000 && (ds_r & DS_ARDY) == 16'h0000))
    else $error("transfer active while ready is set");

  // a word moves only inside a transfer
  a_dma_in_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    res.dma_valid |-> (proc && act_r && item.action == ACT_STEP))
    else $error("word moved without an active transfer");

  // an interrupt from a step always ends the transfer
  a_step_irq_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (proc && item.action == ACT_STEP && irq) |=> !act_r)
    else $error("step interrupt left transfer running");

  // closing a sector restarts the word position
  a_sector_end_pos: assert property (@(posedge clk) disable iff (!rst_n)
    res.sector_end |=> (pos_r == 8'h00))
    else $error("word position not cleared at sector end");

endmodule

### sv/cartridge_disk_controller.sv
// path: a request is captured in the input register, and its result is then registered in
// the result register, from which it is offered on the result channel
// throughput: one request per cycle; the result register and input register advance
// together whenever the result slot is empty or being taken
// reset: synchronous active-low rst_n restores all controller registers and both config
// registers; no clearing pass, requests are taken in the first cycle after reset
module cartridge_disk_controller
  import cdc_pkg::*;
#(
  parameter int DRIVE_UNITS = DRIVE_UNITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  // request channel
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        in_action,
  input  logic [2:0]        in_reg_index,
  input  logic              in_byte_access,
  input  logic              in_odd_byte,
  input  logic [15:0]       in_write_data,
  // result channel
  output logic              out_valid,
  input  logic              out_stall,
  output logic [15:0]       out_read_data,
  output logic              out_dma_valid,
  output logic [17:0]       out_dma_addr,
  output logic              out_dma_to_memory,
  output logic [2:0]        out_drive_unit,
  output logic [12:0]       out_disk_sector,
  output logic [7:0]        out_word_in_sector,
  output logic              out_sector_end,
  output logic              out_interrupt_request,
  output logic              out_busy_res,
  // configuration port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready
);

  logic                   s1_valid_r, s1_valid_nxt;
  item_t                  s1_item_r;
  logic                   out_valid_r, out_valid_nxt;
  result_t                out_r;
  result_t                res;
  logic                   advance;
  logic                   proc;
  logic [DRIVE_UNITS-1:0] drives_attached;
  logic [LIMIT_W-1:0]     memory_limit;

  cdc_cfg #(.DRIVE_UNITS(DRIVE_UNITS)) u_cfg (
    .clk             (clk),
    .rst_n           (rst_n),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .drives_attached (drives_attached),
    .memory_limit    (memory_limit)
  );

  cdc_core #(.DRIVE_UNITS(DRIVE_UNITS)) u_core (
    .clk             (clk),
    .rst_n           (rst_n),
    .proc            (proc),
    .item            (s1_item_r),
    .drives_attached (drives_attached),
    .memory_limit    (memory_limit),
    .res             (res)
  );

  // pipeline flow control
  assign advance  = !out_valid_r || !out_stall;
  assign proc     = s1_valid_r && advance;
  assign in_stall = s1_valid_r && !advance;

  always_comb begin
    s1_valid_nxt  = in_stall ? s1_valid_r : in_valid;
    out_valid_nxt = advance ? s1_valid_r : out_valid_r;
  end

  // valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // input and result payload registers
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_item_r.action      <= in_action;
      s1_item_r.reg_index   <= in_reg_index;
      s1_item_r.byte_access <= in_byte_access;
      s1_item_r.odd_byte    <= in_odd_byte;
      s1_item_r.write_data  <= in_write_data;
    end
    if (proc) begin
      out_r <= res;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_read_data         = out_r.read_data;
  assign out_dma_valid         = out_r.dma_valid;
  assign out_dma_addr          = out_r.dma_addr;
  assign out_dma_to_memory     = out_r.dma_to_memory;
  assign out_drive_unit        = out_r.drive_unit;
  assign out_disk_sector       = out_r.disk_sector;
  assign out_word_in_sector    = out_r.word_in_sector;
  assign out_sector_end        = out_r.sector_end;
  assign out_interrupt_request = out_r.interrupt_request;
  assign out_busy_res          = out_r.busy_res;

endmodule
